[rtl/vdc_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants of the vertex degree counter.
// No dependencies; every other file of the block uses this package.
package vdc_pkg;

	// Default sizing of the degree store.
	localparam int MAX_VERTICES_DEF = 1024;
	localparam int COUNT_BITS_DEF   = 16;

	// Command codes of an input item.
	localparam logic [1:0] CMD_COUNT = 2'd0;
	localparam logic [1:0] CMD_READ  = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;
	localparam logic [1:0] CMD_NONE  = 2'd3;

	// Status codes of a read result.
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_MODE  = 2'd2;

	// Configuration register indexes.
	localparam logic [1:0] CFG_MODE   = 2'd0;
	localparam logic [1:0] CFG_LOOPS  = 2'd1;
	localparam logic [1:0] CFG_DIRECT = 2'd2;
	localparam logic [1:0] CFG_VCOUNT = 2'd3;

	localparam int CFG_DATA_W = 11;

	// Largest degree the output field can show.
	localparam logic [15:0] DEGREE_MAX = 16'hFFFF;

	// One input item.
	typedef struct packed {
		logic [1:0] command;
		logic [9:0] source_vertex;
		logic [9:0] target_vertex;
		logic [9:0] query_vertex;
	} in_item_t;

	// One result item.
	typedef struct packed {
		logic [15:0] degree;
		logic [1:0]  status;
	} out_item_t;

	// Configuration register contents.
	typedef struct packed {
		logic [1:0]  count_mode;
		logic        count_loops;
		logic        is_directed;
		logic [10:0] vertex_count;
	} cfg_t;

endpackage

[rtl/vdc_store.sv]
`timescale 1ns / 1ps
// Degree store: one counter per vertex in a single-port-write,
// single-port-read synchronous memory whose read data is registered.
// Depends on vdc_pkg for default sizing.
module vdc_store #(
	parameter int MAX_VERTICES = vdc_pkg::MAX_VERTICES_DEF,
	parameter int COUNT_BITS   = vdc_pkg::COUNT_BITS_DEF,
	localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1
) (
	input  logic                  clk,
	input  logic                  we,
	input  logic [AW-1:0]         waddr,
	input  logic [COUNT_BITS-1:0] wdata,
	input  logic                  re,
	input  logic [AW-1:0]         raddr,
	output logic [COUNT_BITS-1:0] rdata
);

	logic [COUNT_BITS-1:0] mem [MAX_VERTICES];
	logic [COUNT_BITS-1:0] rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port; the data holds while no read is issued.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[rtl/vdc_ctrl.sv]
`timescale 1ns / 1ps
// Command sequencer: decodes input items, runs the read-modify-write of
// counters, the clearing sweep and the read results. Depends on vdc_pkg.
module vdc_ctrl #(
	parameter int MAX_VERTICES = vdc_pkg::MAX_VERTICES_DEF,
	parameter int COUNT_BITS   = vdc_pkg::COUNT_BITS_DEF,
	localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  vdc_pkg::cfg_t         cfg,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  vdc_pkg::in_item_t     in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output vdc_pkg::out_item_t    out_data,
	output logic                  mem_we,
	output logic [AW-1:0]         mem_waddr,
	output logic [COUNT_BITS-1:0] mem_wdata,
	output logic                  mem_re,
	output logic [AW-1:0]         mem_raddr,
	input  logic [COUNT_BITS-1:0] mem_rdata
);

	localparam int DW = COUNT_BITS + 17;

	typedef enum logic [6:0] {
		S_CLEAR = 7'b0000001,
		S_IDLE  = 7'b0000010,
		S_WR_T  = 7'b0000100,
		S_RD_S  = 7'b0001000,
		S_WR_S  = 7'b0010000,
		S_RESP  = 7'b0100000,
		S_SPARE = 7'b1000000
	} state_t;

	state_t             state_q, state_d;
	logic [AW-1:0]      clr_addr_q;
	logic [AW-1:0]      src_addr_q;
	logic [AW-1:0]      tgt_addr_q;
	logic               do_src_q;
	logic [1:0]         status_q;
	logic               out_valid_q;
	vdc_pkg::out_item_t out_data_q;

	logic               accept;
	logic [1:0]         mode_eff;
	logic               src_ok, tgt_ok, qry_ok;
	logic               edge_ok;
	logic               do_tgt, do_src;
	logic [1:0]         rd_status;
	logic [COUNT_BITS-1:0] incr;
	logic [DW-1:0]      dext;
	logic [15:0]        degree_sat;
	logic               clr_last;

	// A vertex id is valid below both vertex_count and the store depth.
	function automatic logic vtx_valid(input logic [9:0] v, input logic [10:0] vcount);
		return ({1'b0, v} < vcount) && (32'(v) < 32'(MAX_VERTICES));
	endfunction

	function automatic logic [AW-1:0] to_addr(input logic [9:0] v);
		logic [AW+9:0] w;
		w = {{AW{1'b0}}, v};
		return w[AW-1:0];
	endfunction

	// Decode of the item at the input.
	always_comb begin
		mode_eff = cfg.count_mode;
		if (cfg.count_mode != 2'd0 && !cfg.is_directed) begin
			mode_eff = 2'b11;
		end
		src_ok  = vtx_valid(in_data.source_vertex, cfg.vertex_count);
		tgt_ok  = vtx_valid(in_data.target_vertex, cfg.vertex_count);
		qry_ok  = vtx_valid(in_data.query_vertex, cfg.vertex_count);
		edge_ok = (mode_eff != 2'd0) && src_ok && tgt_ok &&
			(cfg.count_loops || in_data.source_vertex != in_data.target_vertex);
		do_tgt  = edge_ok && mode_eff[1];
		do_src  = edge_ok && mode_eff[0];
		if (!qry_ok) begin
			rd_status = vdc_pkg::ST_RANGE;
		end else if (mode_eff == 2'd0) begin
			rd_status = vdc_pkg::ST_MODE;
		end else begin
			rd_status = vdc_pkg::ST_OK;
		end
	end

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == S_IDLE);
	assign clr_last = (clr_addr_q == AW'(MAX_VERTICES - 1));

	// Saturating increment and output clamp of the counter just read.
	assign incr       = (&mem_rdata) ? mem_rdata : mem_rdata + COUNT_BITS'(1);
	assign dext       = DW'(mem_rdata);
	assign degree_sat = (dext > DW'(vdc_pkg::DEGREE_MAX)) ? vdc_pkg::DEGREE_MAX : dext[15:0];

	// Next state and memory requests.
	always_comb begin
		state_d   = state_q;
		mem_we    = 1'b0;
		mem_waddr = clr_addr_q;
		mem_wdata = '0;
		mem_re    = 1'b0;
		mem_raddr = to_addr(in_data.query_vertex);
		unique case (state_q)
			S_CLEAR: begin
				mem_we = 1'b1;
				if (clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (accept) begin
					case (in_data.command)
						vdc_pkg::CMD_COUNT: begin
							if (do_tgt) begin
								mem_re    = 1'b1;
								mem_raddr = to_addr(in_data.target_vertex);
								state_d   = S_WR_T;
							end else if (do_src) begin
								mem_re    = 1'b1;
								mem_raddr = to_addr(in_data.source_vertex);
								state_d   = S_WR_S;
							end
						end
						vdc_pkg::CMD_READ: begin
							mem_re  = (rd_status == vdc_pkg::ST_OK);
							state_d = S_RESP;
						end
						vdc_pkg::CMD_CLEAR: begin
							state_d = S_CLEAR;
						end
						default: begin
							state_d = S_IDLE;
						end
					endcase
				end
			end
			S_WR_T: begin
				mem_we    = 1'b1;
				mem_waddr = tgt_addr_q;
				mem_wdata = incr;
				state_d   = do_src_q ? S_RD_S : S_IDLE;
			end
			S_RD_S: begin
				mem_re    = 1'b1;
				mem_raddr = src_addr_q;
				state_d   = S_WR_S;
			end
			S_WR_S: begin
				mem_we    = 1'b1;
				mem_waddr = src_addr_q;
				mem_wdata = incr;
				state_d   = S_IDLE;
			end
			S_RESP: begin
				if (!out_valid_q || out_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control state; reset starts with a sweep that zeroes the store.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_addr_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR) begin
				clr_addr_q <= clr_last ? '0 : clr_addr_q + AW'(1);
			end
			if (state_q == S_RESP && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Item fields held for the later steps of a command.
	always_ff @(posedge clk) begin
		if (accept) begin
			src_addr_q <= to_addr(in_data.source_vertex);
			tgt_addr_q <= to_addr(in_data.target_vertex);
			do_src_q   <= do_src;
			status_q   <= rd_status;
		end
	end

	// Output register loaded from the read data or the error status.
	always_ff @(posedge clk) begin
		if (state_q == S_RESP && (!out_valid_q || out_ready)) begin
			out_data_q.status <= status_q;
			out_data_q.degree <= (status_q == vdc_pkg::ST_OK) ? degree_sat : 16'd0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

[rtl/vertex_degree_counter_core.sv]
`timescale 1ns / 1ps
// Vertex degree counter top level: configuration registers, sequencer and
// degree store. Depends on vdc_pkg, vdc_ctrl and vdc_store.
// A read is answered from the registered store read through the output register;
// a count does one read and one write per counter bumped, through the
// single memory port pair; a clear writes zero to every store address.
// Reset clears the control state and runs a sweep that zeroes the store
// before the first input transfer; configuration resets too.
module vertex_degree_counter_core #(
	parameter int MAX_VERTICES = vdc_pkg::MAX_VERTICES_DEF,
	parameter int COUNT_BITS   = vdc_pkg::COUNT_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [1:0]                        cfg_idx,
	input  logic [vdc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  vdc_pkg::in_item_t                 in_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output vdc_pkg::out_item_t                out_data
);

	localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;

	vdc_pkg::cfg_t         cfg_q;
	logic                  mem_we;
	logic [AW-1:0]         mem_waddr;
	logic [COUNT_BITS-1:0] mem_wdata;
	logic                  mem_re;
	logic [AW-1:0]         mem_raddr;
	logic [COUNT_BITS-1:0] mem_rdata;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.count_mode   <= 2'd3;
			cfg_q.count_loops  <= 1'b1;
			cfg_q.is_directed  <= 1'b1;
			cfg_q.vertex_count <= 11'd1024;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				vdc_pkg::CFG_MODE:   cfg_q.count_mode   <= cfg_wdata[1:0];
				vdc_pkg::CFG_LOOPS:  cfg_q.count_loops  <= cfg_wdata[0];
				vdc_pkg::CFG_DIRECT: cfg_q.is_directed  <= cfg_wdata[0];
				vdc_pkg::CFG_VCOUNT: cfg_q.vertex_count <= cfg_wdata;
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	vdc_ctrl #(
		.MAX_VERTICES(MAX_VERTICES),
		.COUNT_BITS  (COUNT_BITS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.mem_we   (mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata),
		.mem_re   (mem_re),
		.mem_raddr(mem_raddr),
		.mem_rdata(mem_rdata)
	);

	vdc_store #(
		.MAX_VERTICES(MAX_VERTICES),
		.COUNT_BITS  (COUNT_BITS)
	) u_store (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

endmodule

[verif/tb_vertex_degree_counter_core.sv]
`timescale 1ns / 1ps
// Self-checking testbench for vertex_degree_counter_core: directed, self-loop
// and random edge streams checked against a degree predictor in a scoreboard.
// Depends on vdc_pkg and the vertex_degree_counter_core RTL.
module tb_vertex_degree_counter_core;

	localparam int SETTLE_CYCLES  = vdc_pkg::MAX_VERTICES_DEF + 64;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int PHASE_ITEMS    = 205;
	localparam int NUM_PHASES     = 8;
	localparam int MAX_REPORTS    = 10;
	localparam int LOOP_EDGES     = 20;

	// Predicts read results from the edge stream and checks the block's answers.
	class degree_scoreboard;
		logic [15:0]        degree_mem [vdc_pkg::MAX_VERTICES_DEF];
		logic [1:0]         mode;
		logic               loops;
		logic               directed;
		logic [10:0]        vcount;
		vdc_pkg::out_item_t pending_reads [$];
		int                 fail_count;

		function new();
			foreach (degree_mem[i]) degree_mem[i] = '0;
			mode       = 2'd3;
			loops      = 1'b1;
			directed   = 1'b1;
			vcount     = 11'd1024;
			fail_count = 0;
		endfunction

		function void log_fail(string what);
			if (fail_count < MAX_REPORTS) begin
				$display("%s", what);
			end
			fail_count++;
		endfunction

		function int vertex_bound();
			return (vcount < vdc_pkg::MAX_VERTICES_DEF) ? int'(vcount)
				: vdc_pkg::MAX_VERTICES_DEF;
		endfunction

		function void set_reg(logic [1:0] idx, logic [vdc_pkg::CFG_DATA_W-1:0] val);
			case (idx)
				vdc_pkg::CFG_MODE:   mode = val[1:0];
				vdc_pkg::CFG_LOOPS:  loops = val[0];
				vdc_pkg::CFG_DIRECT: directed = val[0];
				vdc_pkg::CFG_VCOUNT: vcount = val[10:0];
				default:             ;
			endcase
		endfunction

		// The counter and the degree field share 16 bits, so one limit serves both.
		function void bump(int v);
			if (degree_mem[v] != vdc_pkg::DEGREE_MAX) begin
				degree_mem[v] = degree_mem[v] + 16'd1;
			end
		endfunction

		// Applies one accepted input; rejected edges and unused commands change nothing.
		function void apply_item(vdc_pkg::in_item_t item);
			logic [1:0]         eff_mode;
			int                 bound;
			vdc_pkg::out_item_t res;
			bound    = vertex_bound();
			eff_mode = (mode != 2'd0 && !directed) ? 2'd3 : mode;
			case (item.command)
				vdc_pkg::CMD_COUNT: begin
					if (eff_mode != 2'd0 && item.source_vertex < bound
							&& item.target_vertex < bound
							&& (loops || item.source_vertex != item.target_vertex)) begin
						if (eff_mode[1]) bump(item.target_vertex);
						if (eff_mode[0]) bump(item.source_vertex);
					end
				end
				vdc_pkg::CMD_READ: begin
					// A range error wins over an invalid mode.
					if (item.query_vertex >= bound) begin
						res.degree = '0;
						res.status = vdc_pkg::ST_RANGE;
					end else if (eff_mode == 2'd0) begin
						res.degree = '0;
						res.status = vdc_pkg::ST_MODE;
					end else begin
						res.degree = degree_mem[item.query_vertex];
						res.status = vdc_pkg::ST_OK;
					end
					pending_reads.push_back(res);
				end
				vdc_pkg::CMD_CLEAR: begin
					foreach (degree_mem[i]) degree_mem[i] = '0;
				end
				default: ;
			endcase
		endfunction

		function void check_result(vdc_pkg::out_item_t got);
			vdc_pkg::out_item_t want;
			if (pending_reads.size() == 0) begin
				log_fail($sformatf("unexpected read result: degree %0d status %0d",
					got.degree, got.status));
				return;
			end
			want = pending_reads.pop_front();
			if (got.degree !== want.degree || got.status !== want.status) begin
				log_fail($sformatf({"read mismatch: expected degree %0d status %0d,",
					" got degree %0d status %0d"},
					want.degree, want.status, got.degree, got.status));
			end
		endfunction

		function void check_drained();
			if (pending_reads.size() != 0) begin
				log_fail($sformatf("%0d read results never arrived", pending_reads.size()));
			end
		endfunction
	endclass

	logic                           clk;
	logic                           arst_n;
	logic                           cfg_we;
	logic [1:0]                     cfg_idx;
	logic [vdc_pkg::CFG_DATA_W-1:0] cfg_wdata;
	logic                           in_valid;
	logic                           in_ready;
	vdc_pkg::in_item_t              in_data;
	logic                           out_valid;
	logic                           out_ready;
	vdc_pkg::out_item_t             out_data;

	int send_idle_pct;
	int recv_stall_pct;
	int idle_cycles;

	degree_scoreboard sb = new();

	vertex_degree_counter_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	// Free-running clock with a 4 ns period.
	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// The receiver stalls at random at the rate the current phase asks for.
	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Every result transfer is checked against the oldest expected read.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			sb.check_result(out_data);
		end
	end

	// The run ends as a failure when no transfer happens for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("vertex_degree_counter_core regression: fail");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	function automatic vdc_pkg::in_item_t make_item(logic [1:0] cmd, int src, int tgt,
			int qv);
		vdc_pkg::in_item_t item;
		item.command       = cmd;
		item.source_vertex = src[9:0];
		item.target_vertex = tgt[9:0];
		item.query_vertex  = qv[9:0];
		return item;
	endfunction

	// Vertex ids cluster on a few low ids and around the valid bound.
	function automatic int pick_vertex(int bound);
		int v;
		case ($urandom_range(9)) inside
			[0:3]:   v = int'($urandom_range(15));
			[4:5]:   v = bound - 2 + int'($urandom_range(3));
			default: v = int'($urandom_range(1023));
		endcase
		if (v < 0) v = 0;
		if (v > 1023) v = 1023;
		return v;
	endfunction

	function automatic vdc_pkg::in_item_t random_item();
		int         bound;
		int         src;
		int         tgt;
		int         pick;
		logic [1:0] cmd;
		bound = sb.vertex_bound();
		pick  = int'($urandom_range(99));
		if (pick < 64) cmd = vdc_pkg::CMD_COUNT;
		else if (pick < 92) cmd = vdc_pkg::CMD_READ;
		else if (pick < 93) cmd = vdc_pkg::CMD_CLEAR;
		else cmd = vdc_pkg::CMD_NONE;
		src = pick_vertex(bound);
		tgt = ($urandom_range(9) == 0) ? src : pick_vertex(bound);
		return make_item(cmd, src, tgt, pick_vertex(bound));
	endfunction

	// Offers one item after an optional random gap and waits for its transfer.
	task automatic send(input vdc_pkg::in_item_t item);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= item;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.apply_item(item);
		@(negedge clk);
	endtask

	// Drains all reads, then gives a clear or count still in flight time to end.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (sb.pending_reads.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	// Leaves the write enable high so back-to-back writes never toggle it.
	task automatic write_reg(input logic [1:0] idx, input int val);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= val[vdc_pkg::CFG_DATA_W-1:0];
		@(posedge clk);
		sb.set_reg(idx, val[vdc_pkg::CFG_DATA_W-1:0]);
		@(negedge clk);
	endtask

	task automatic program_registers(input int mode, input int loops, input int dir,
			input int vcount);
		write_reg(vdc_pkg::CFG_MODE, mode);
		write_reg(vdc_pkg::CFG_LOOPS, loops);
		write_reg(vdc_pkg::CFG_DIRECT, dir);
		write_reg(vdc_pkg::CFG_VCOUNT, vcount);
		cfg_we <= 1'b0;
	endtask

	initial begin
		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_idx        = vdc_pkg::CFG_MODE;
		cfg_wdata      = '0;
		in_valid       = 1'b0;
		in_data        = '0;
		out_ready      = 1'b0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		idle_cycles    = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		wait_idle();

		// Directed part, starting from the reset configuration.
		program_registers(3, 1, 1, 1024);
		send(make_item(vdc_pkg::CMD_READ, 0, 0, 0));
		send(make_item(vdc_pkg::CMD_COUNT, 0, 1023, 0));
		send(make_item(vdc_pkg::CMD_READ, 0, 0, 1023));
		send(make_item(vdc_pkg::CMD_COUNT, 1023, 1023, 0));
		send(make_item(vdc_pkg::CMD_READ, 0, 0, 1023));
		send(make_item(vdc_pkg::CMD_NONE, 1023, 1023, 1023));
		send(make_item(vdc_pkg::CMD_COUNT, 3, 4, 0));
		send(make_item(vdc_pkg::CMD_READ, 0, 0, 3));

		// Skipped loop and edges with one endpoint past the bound.
		wait_idle();
		program_registers(3, 0, 1, 4);
		send(make_item(vdc_pkg::CMD_COUNT, 3, 3, 0));
		send(make_item(vdc_pkg::CMD_COUNT, 2, 4, 0));
		send(make_item(vdc_pkg::CMD_COUNT, 4, 2, 0));
		send(make_item(vdc_pkg::CMD_READ, 0, 0, 3));
		send(make_item(vdc_pkg::CMD_READ, 0, 0, 4));

		// Invalid mode on an undirected graph; a range error still wins.
		wait_idle();
		program_registers(0, 1, 0, 4);
		send(make_item(vdc_pkg::CMD_COUNT, 1, 2, 0));
		send(make_item(vdc_pkg::CMD_READ, 0, 0, 1));
		send(make_item(vdc_pkg::CMD_READ, 0, 0, 1023));

		// In-degree only, then a clear, then out-degree only.
		wait_idle();
		program_registers(2, 1, 1, 1024);
		send(make_item(vdc_pkg::CMD_COUNT, 5, 6, 0));
		send(make_item(vdc_pkg::CMD_READ, 0, 0, 5));
		send(make_item(vdc_pkg::CMD_READ, 0, 0, 6));
		send(make_item(vdc_pkg::CMD_CLEAR, 0, 0, 0));
		send(make_item(vdc_pkg::CMD_READ, 0, 0, 1023));
		send(make_item(vdc_pkg::CMD_READ, 0, 0, 6));
		wait_idle();
		program_registers(1, 1, 1, 1024);
		send(make_item(vdc_pkg::CMD_COUNT, 8, 9, 0));
		send(make_item(vdc_pkg::CMD_READ, 0, 0, 8));
		send(make_item(vdc_pkg::CMD_READ, 0, 0, 9));

		// Back-to-back self-loops on an undirected graph add two each.
		wait_idle();
		program_registers(3, 1, 0, 1024);
		for (int i = 0; i < LOOP_EDGES; i++) begin
			send(make_item(vdc_pkg::CMD_COUNT, 7, 7, 0));
			if (i >= LOOP_EDGES - 5) send(make_item(vdc_pkg::CMD_READ, 0, 0, 7));
		end

		// Random phases, each with its own configuration and one of four idling patterns.
		for (int p = 0; p < NUM_PHASES; p++) begin
			wait_idle();
			case (p)
				0: program_registers(3, 1, 1, 1024);
				1: program_registers(1, 0, 1, 1000);
				2: program_registers(2, 1, 1, 2047);
				3: program_registers(0, 1, 0, 512);
				4: program_registers(3, 0, 0, 1);
				5: program_registers(1, 1, 0, 0);
				6: program_registers(2, 0, 1, 2);
				default: program_registers($urandom_range(3), $urandom_range(1),
					$urandom_range(1), $urandom_range(1100));
			endcase
			case (p % 4)
				0: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct  = 60;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct  = 0;
					recv_stall_pct = 60;
				end
				default: begin
					send_idle_pct  = 28;
					recv_stall_pct = 28;
				end
			endcase
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				send(random_item());
			end
		end

		wait_idle();
		sb.check_drained();
		if (sb.fail_count == 0) begin
			$display("vertex_degree_counter_core regression: pass");
		end else begin
			$display("vertex_degree_counter_core regression: fail");
		end
		$finish;
	end

endmodule
